/* rtl/core/sta_pkg.sv */
// sta_pkg: shared types, constants and width helpers for the sensor tare averager
// used by sta_ctrl and sensor_tare_averager_top; no dependencies
package sta_pkg;

	localparam int DEF_HISTORY_DEPTH = 16;
	localparam int DEF_SAMPLE_BITS   = 12;

	localparam int RAW_W      = 12;
	localparam int CFG_W      = 12;
	localparam int FRAC_W     = 4;
	localparam int TARE_W     = 16;
	localparam int DIFF_W     = 17;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 40;

	typedef enum logic [0:0] {
		REG_MIN_VALID = 1'b0,
		REG_MAX_VALID = 1'b1
	} sta_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SAMPLE,
		ST_ACCUM,
		ST_TARE,
		ST_FINISH
	} sta_state_t;

	typedef struct packed {
		logic sample_en;
		logic acc_init;
		logic rd_en;
		logic tare_load;
		logic out_load;
	} sta_ctl_t;

	function automatic int sample_width(input int sbits);
		return (sbits < RAW_W) ? sbits : RAW_W;
	endfunction

	// numerator of the rounded mean: sum * 16 + depth / 2
	function automatic int num_width(input int depth, input int sbits);
		return sample_width(sbits) + FRAC_W + $clog2(depth);
	endfunction

	function automatic int cnt_width(input int depth);
		return $clog2(depth + 1);
	endfunction

endpackage

/* rtl/core/sta_alu.sv */
// sta_alu: shared add / subtract unit used for accumulation and for tare
// removal; no dependencies
module sta_alu #(
	parameter int W = 16
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W:0]   y
);

	// y[W] is the carry on add, the borrow on subtract
	always_comb begin
		if (sub) begin
			y = {1'b0, a} - {1'b0, b};
		end else begin
			y = {1'b0, a} + {1'b0, b};
		end
	end

endmodule

/* rtl/core/sta_hist.sv */
// sta_hist: ring history memory, one write port and one registered read port
// no dependencies
module sta_hist #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/sta_ctrl.sv */
// sta_ctrl: sequencer for sample and zero requests, with the step counter
// depends on sta_pkg
module sta_ctrl #(
	parameter int HISTORY_DEPTH = sta_pkg::DEF_HISTORY_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_action,
	input  logic                 out_free,
	output logic                 in_ready,
	output sta_pkg::sta_ctl_t    ctl,
	output logic [sta_pkg::cnt_width(HISTORY_DEPTH)-1:0] cnt
);

	localparam int CW = sta_pkg::cnt_width(HISTORY_DEPTH);

	sta_pkg::sta_state_t state_q, state_d;
	logic [CW-1:0]       cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sta_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = in_action ? sta_pkg::ST_ACCUM : sta_pkg::ST_SAMPLE;
				end
			end
			sta_pkg::ST_SAMPLE: state_d = sta_pkg::ST_FINISH;
			sta_pkg::ST_ACCUM: begin
				if (cnt_q == CW'(HISTORY_DEPTH)) begin
					state_d = sta_pkg::ST_TARE;
				end
			end
			sta_pkg::ST_TARE: state_d = sta_pkg::ST_FINISH;
			sta_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = sta_pkg::ST_IDLE;
				end
			end
			default: state_d = sta_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		ctl           = '0;
		unique case (state_q)
			sta_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				ctl.acc_init = in_valid & in_action;
			end
			sta_pkg::ST_SAMPLE: ctl.sample_en = 1'b1;
			sta_pkg::ST_ACCUM:  ctl.rd_en     = (cnt_q < CW'(HISTORY_DEPTH));
			sta_pkg::ST_TARE:   ctl.tare_load = 1'b1;
			sta_pkg::ST_FINISH: ctl.out_load  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sta_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	assign cnt = cnt_q;

endmodule

/* rtl/core/sensor_tare_averager_top.sv */
// sensor_tare_averager_top: range check, ring history and tare removal for adc samples
// depends on sta_pkg, sta_alu, sta_hist, sta_ctrl
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata: raw_sample; s_tuser: action
// m_       out  m_tvalid/m_tready  m_tdata: tared_pressure, in_range, sensor_ok,
//                                           zero_ready, tare_value
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data (min_valid, max_valid)
//
// a sample request makes one pass through the shared adder in ST_SAMPLE after acceptance
// a zero request reads and accumulates the history in ST_ACCUM, forms the mean by
// reciprocal multiplication and loads the tare in ST_TARE, then outputs in ST_FINISH
// the history is a single-port-read memory; unwritten entries are masked as zero
// the result load waits while a full output register is not taken; the next request
// is accepted in the cycle after the load; asynchronous reset clears history index,
// zero_ready, tare and min limit, sets sensor_ok and max limit; cfg_ready is always high
module sensor_tare_averager_top #(
	parameter int HISTORY_DEPTH = sta_pkg::DEF_HISTORY_DEPTH,
	parameter int SAMPLE_BITS   = sta_pkg::DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sta_pkg::S_TDATA_W-1:0] s_tdata,  // [11:0] raw_sample, [15:12] zero
	input  logic                          s_tuser,  // [0] action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sta_pkg::M_TDATA_W-1:0] m_tdata,  // [16:0] tared_pressure, [17] in_range,
	                                                // [18] sensor_ok, [19] zero_ready,
	                                                // [35:20] tare_value, [39:36] zero
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [sta_pkg::CFG_W-1:0]     cfg_data
);

	localparam int SW   = sta_pkg::sample_width(SAMPLE_BITS);
	localparam int NW   = sta_pkg::num_width(HISTORY_DEPTH, SAMPLE_BITS);
	localparam int CW   = sta_pkg::cnt_width(HISTORY_DEPTH);
	localparam int AW   = (NW > sta_pkg::TARE_W) ? NW : sta_pkg::TARE_W;
	localparam int KSH  = NW + $clog2(HISTORY_DEPTH);
	localparam int MW   = NW + 1;
	localparam int PW   = NW + MW;
	localparam int QW   = PW - KSH;
	localparam int QXW  = (QW > sta_pkg::TARE_W) ? QW : sta_pkg::TARE_W + 1;
	localparam logic [63:0] RECIP = ((64'd1 << KSH) + 64'(HISTORY_DEPTH - 1)) /
	                                64'(HISTORY_DEPTH);
	localparam int HW   = $clog2(HISTORY_DEPTH);
	localparam int IW   = $clog2(HISTORY_DEPTH + 1);
	localparam int HALF = HISTORY_DEPTH / 2;
	localparam int PADW = sta_pkg::M_TDATA_W - sta_pkg::DIFF_W - 3 - sta_pkg::TARE_W;

	sta_pkg::sta_ctl_t ctl;
	logic [CW-1:0]     cnt;
	logic              out_free;
	logic              s_accept;

	logic [SW-1:0]     min_q, max_q;
	logic [IW-1:0]     wi_q;
	logic              ready_q, ok_q;
	logic [sta_pkg::TARE_W-1:0] tare_q;
	logic              m_tvalid_q;
	logic [sta_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic              act_q;
	logic [SW-1:0]     s_q;
	logic [sta_pkg::DIFF_W-1:0] diff_q;
	logic              inr_q;
	logic [AW-1:0]     acc_q;
	logic              add_s1, ev_s1;

	logic [AW-1:0]     alu_a, alu_b;
	logic              alu_sub;
	logic [AW:0]       alu_y;
	logic [SW-1:0]     hist_rdata;
	logic              wrap;
	logic [HW-1:0]     hist_waddr;
	logic              inr;
	logic              entry_valid;
	logic [PW-1:0]     prod;
	logic [QXW-1:0]    q_ext;
	logic [sta_pkg::TARE_W-1:0] tare_next;
	logic [sta_pkg::DIFF_W-1:0] res_diff;
	logic              res_inr;

	assign s_accept  = s_tvalid & s_tready;
	assign out_free  = ~m_tvalid_q | m_tready;
	assign cfg_ready = 1'b1;

	sta_ctrl #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (s_tuser),
		.out_free  (out_free),
		.in_ready  (s_tready),
		.ctl       (ctl),
		.cnt       (cnt)
	);

	assign wrap       = (wi_q == IW'(HISTORY_DEPTH));
	assign hist_waddr = wrap ? '0 : wi_q[HW-1:0];

	sta_hist #(
		.DEPTH (HISTORY_DEPTH),
		.WIDTH (SW)
	) u_hist (
		.clk   (clk),
		.we    (ctl.sample_en),
		.waddr (hist_waddr),
		.wdata (s_q),
		.re    (ctl.rd_en),
		.raddr (cnt[HW-1:0]),
		.rdata (hist_rdata)
	);

	always_comb begin
		if (add_s1) begin
			alu_a   = acc_q;
			alu_b   = ev_s1 ? AW'({hist_rdata, 4'b0000}) : '0;
			alu_sub = 1'b0;
		end else begin
			alu_a   = AW'({s_q, 4'b0000});
			alu_b   = AW'(tare_q);
			alu_sub = 1'b1;
		end
	end

	sta_alu #(
		.W (AW)
	) u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y)
	);

	// mean by reciprocal multiplication, exact for any numerator below 2**NW
	assign prod        = PW'(acc_q[NW-1:0]) * PW'(RECIP[MW-1:0]);
	assign inr         = (s_q > min_q) && (s_q < max_q);
	assign entry_valid = ready_q || (cnt < CW'(wi_q));
	assign q_ext       = QXW'(prod[PW-1:KSH]);
	assign tare_next   = (|q_ext[QXW-1:sta_pkg::TARE_W]) ? '1 : q_ext[sta_pkg::TARE_W-1:0];
	assign res_diff    = act_q ? '0 : diff_q;
	assign res_inr     = act_q ? 1'b0 : inr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q      <= '0;
			max_q      <= '1;
			wi_q       <= '0;
			ready_q    <= 1'b0;
			ok_q       <= 1'b1;
			tare_q     <= '0;
			m_tvalid_q <= 1'b0;
			add_s1     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (sta_pkg::sta_reg_t'(cfg_index))
					sta_pkg::REG_MIN_VALID: min_q <= cfg_data[SW-1:0];
					sta_pkg::REG_MAX_VALID: max_q <= cfg_data[SW-1:0];
					default: ;
				endcase
			end
			if (ctl.sample_en) begin
				ok_q <= ok_q & inr;
				if (wrap) begin
					wi_q    <= IW'(1);
					ready_q <= 1'b1;
				end else begin
					wi_q <= wi_q + IW'(1);
				end
			end
			if (ctl.tare_load) begin
				tare_q <= tare_next;
			end
			add_s1 <= ctl.rd_en;
			if (ctl.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			act_q <= s_tuser;
			s_q   <= s_tdata[SW-1:0];
		end
		if (ctl.sample_en) begin
			diff_q <= alu_y[sta_pkg::DIFF_W-1:0];
			inr_q  <= inr;
		end
		ev_s1 <= entry_valid;
		// acc holds the rounded-mean numerator
		if (ctl.acc_init) begin
			acc_q <= AW'(HALF);
		end else if (add_s1) begin
			acc_q <= alu_y[AW-1:0];
		end
		if (ctl.out_load) begin
			m_tdata_q <= {{PADW{1'b0}}, tare_q, ready_q, ok_q, res_inr, res_diff};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_ok_sticky: assert property (@(posedge clk) disable iff (!arst_n) !$rose(ok_q))
		else $error("sensor_ok set again after clearing");

	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n) !$fell(ready_q))
		else $error("zero_ready cleared after being set");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wi_q <= IW'(HISTORY_DEPTH))
		else $error("history index beyond depth");

	a_tare_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(ctl.tare_load) |-> $stable(tare_q))
		else $error("tare changed outside a zero request");

endmodule

/* tb/sensor_tare_averager_top_tb.sv */
// sensor_tare_averager_top_tb: self-checking bench for the tare averager, driving sample and
// zero requests and comparing every result against an in-bench model of history and tare
// depends on sta_pkg and sensor_tare_averager_top
`timescale 1ns / 1ps

module sensor_tare_averager_top_tb;

	localparam int DEPTH          = sta_pkg::DEF_HISTORY_DEPTH;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 60;

	typedef struct {
		logic signed [sta_pkg::DIFF_W-1:0] tared;
		logic                              in_range;
		logic                              sensor_ok;
		logic                              zero_ready;
		logic [sta_pkg::TARE_W-1:0]        tare_value;
	} reading_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [sta_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic                          s_tuser = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [sta_pkg::M_TDATA_W-1:0] m_tdata;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic                          cfg_index = 1'b0;
	logic [sta_pkg::CFG_W-1:0]     cfg_data = '0;

	// model state
	logic [sta_pkg::RAW_W-1:0]  hist_mem [DEPTH];
	int                         hist_wr_ptr;
	logic [sta_pkg::TARE_W-1:0] tare_q;
	logic                       ready_flag;
	logic                       ok_flag;
	logic [sta_pkg::CFG_W-1:0]  lim_min;
	logic [sta_pkg::CFG_W-1:0]  lim_max;

	reading_t pending_readings [$];
	int       mismatch_count = 0;
	int       stall_cycles = 0;
	int       src_idle_pct = 0;
	int       sink_stall_pct = 0;

	sensor_tare_averager_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic reading_t predict_reading(input logic zero_cmd,
	                                             input logic [sta_pkg::RAW_W-1:0] raw);
		reading_t r;
		int       diff;
		int       sum;
		int       mean;
		r.tared    = '0;
		r.in_range = 1'b0;
		if (!zero_cmd) begin
			r.in_range = (raw > lim_min) && (raw < lim_max);
			if (!r.in_range)
				ok_flag = 1'b0;
			if (hist_wr_ptr >= DEPTH) begin
				hist_wr_ptr = 0;
				ready_flag  = 1'b1;
			end
			hist_mem[hist_wr_ptr] = raw;
			hist_wr_ptr++;
			diff = int'(raw) * 16 - int'(tare_q);
			if (diff > 65535)
				diff = 65535;
			if (diff < -65536)
				diff = -65536;
			r.tared = diff[sta_pkg::DIFF_W-1:0];
		end else begin
			sum = 0;
			for (int i = 0; i < DEPTH; i++)
				sum += int'(hist_mem[i]);
			mean = (sum * 16 + DEPTH / 2) / DEPTH;
			if (mean > 65535)
				mean = 65535;
			tare_q = mean[sta_pkg::TARE_W-1:0];
		end
		r.sensor_ok  = ok_flag;
		r.zero_ready = ready_flag;
		r.tare_value = tare_q;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_reading(input logic [sta_pkg::M_TDATA_W-1:0] data);
		reading_t want;
		logic signed [sta_pkg::DIFF_W-1:0] got_tared;
		if (pending_readings.size() == 0) begin
			report_mismatch("unexpected result, tdata low word", int'(data[31:0]), 0);
		end else begin
			want      = pending_readings.pop_front();
			got_tared = data[16:0];
			if (got_tared !== want.tared)
				report_mismatch("tared_pressure", int'(got_tared), int'(want.tared));
			if (data[17] !== want.in_range)
				report_mismatch("in_range", int'(data[17]), int'(want.in_range));
			if (data[18] !== want.sensor_ok)
				report_mismatch("sensor_ok", int'(data[18]), int'(want.sensor_ok));
			if (data[19] !== want.zero_ready)
				report_mismatch("zero_ready", int'(data[19]), int'(want.zero_ready));
			if (data[35:20] !== want.tare_value)
				report_mismatch("tare_value", int'(data[35:20]), int'(want.tare_value));
		end
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
		if (arst_n && m_tvalid && m_tready)
			check_reading(m_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("sensor_tare_averager_top verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_request(input logic zero_cmd, input logic [sta_pkg::RAW_W-1:0] raw);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= zero_cmd;
		s_tdata  <= {4'b0000, raw};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_readings.push_back(predict_reading(zero_cmd, raw));
	endtask

	task automatic drain_readings();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_readings.size() != 0);
	endtask

	task automatic write_limit(input sta_pkg::sta_reg_t idx,
	                           input logic [sta_pkg::CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			sta_pkg::REG_MIN_VALID: lim_min = val;
			sta_pkg::REG_MAX_VALID: lim_max = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input logic [sta_pkg::CFG_W-1:0] lo,
	                          input logic [sta_pkg::CFG_W-1:0] hi);
		drain_readings();
		write_limit(sta_pkg::REG_MIN_VALID, lo);
		write_limit(sta_pkg::REG_MAX_VALID, hi);
	endtask

	task automatic test_reset_state();
		send_request(1'b1, 12'h000);
		send_request(1'b0, 12'd2048);
		send_request(1'b0, 12'hAAA);
		send_request(1'b0, 12'h555);
	endtask

	task automatic test_range_limits();
		send_request(1'b0, 12'd0);
		send_request(1'b0, 12'd4095);
		send_request(1'b0, 12'd1);
		send_request(1'b0, 12'd4094);
		set_limits(12'd4095, 12'd0);
		send_request(1'b0, 12'd2048);
		set_limits(12'd100, 12'd200);
		send_request(1'b0, 12'd100);
		send_request(1'b0, 12'd101);
		send_request(1'b0, 12'd199);
		send_request(1'b0, 12'd200);
		set_limits(12'd0, 12'd4095);
	endtask

	task automatic test_history_wrap();
		send_request(1'b1, 12'hFFF);
		for (int i = 0; i < DEPTH + 1; i++)
			send_request(1'b0, 12'd4095);
		send_request(1'b1, 12'h000);
		send_request(1'b0, 12'd0);
		send_request(1'b0, 12'd4095);
	endtask

	task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items,
	                                   input logic [sta_pkg::CFG_W-1:0] lo,
	                                   input logic [sta_pkg::CFG_W-1:0] hi);
		logic                      zero_cmd;
		logic [sta_pkg::RAW_W-1:0] raw;
		set_limits(lo, hi);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		for (int n = 0; n < n_items; n++) begin
			zero_cmd = ($urandom_range(9) == 0);
			case ($urandom_range(3))
				0:       raw = lim_min + 12'($urandom_range(2)) - 12'd1;
				1:       raw = lim_max + 12'($urandom_range(2)) - 12'd1;
				default: raw = 12'($urandom_range(4095));
			endcase
			if ($urandom_range(39) == 0)
				drain_readings();
			send_request(zero_cmd, raw);
		end
	endtask

	initial begin
		logic [sta_pkg::CFG_W-1:0] lo_a;
		logic [sta_pkg::CFG_W-1:0] hi_a;
		logic [sta_pkg::CFG_W-1:0] lo_b;
		logic [sta_pkg::CFG_W-1:0] hi_b;
		for (int i = 0; i < DEPTH; i++)
			hist_mem[i] = '0;
		hist_wr_ptr = 0;
		tare_q      = '0;
		ready_flag  = 1'b0;
		ok_flag     = 1'b1;
		lim_min     = '0;
		lim_max     = 12'd4095;
		lo_a = 12'($urandom_range(1500));
		hi_a = 12'($urandom_range(4095, 2500));
		lo_b = 12'($urandom_range(2000, 1000));
		hi_b = 12'($urandom_range(3000, 2100));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_range_limits();
		test_history_wrap();
		test_random_traffic(25, 57, 134, lo_a, hi_a);
		test_random_traffic(57, 25, 134, lo_b, hi_b);
		test_random_traffic(0, 0, 134, 12'd0, 12'd4095);

		drain_readings();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_readings.size() == 0)
			$display("sensor_tare_averager_top verification clean");
		else
			$display("sensor_tare_averager_top verification failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/sta_pkg.sv
rtl/core/sta_alu.sv
rtl/core/sta_hist.sv
rtl/core/sta_ctrl.sv
rtl/core/sensor_tare_averager_top.sv
tb/sensor_tare_averager_top_tb.sv
